FILE: rtl/assert_macros.svh
// Assertion macros for the RTL that checks its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define JSU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define JSU_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: rtl/jsu_pkg.sv
// Shared types, constants and decode functions of the JSON string unescaper.
package jsu_pkg;

    // Parser modes
    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_STR,
        MODE_ESC,
        MODE_HEX1,
        MODE_SBS,
        MODE_SU,
        MODE_HEX2
    } t_mode;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_BYTE,
        KIND_DONE,
        KIND_ERROR
    } t_kind;

    // Error codes
    typedef enum logic [3:0] {
        ERR_EXPECTED,
        ERR_CONTROL,
        ERR_UNTERM_ESC,
        ERR_BAD_ESC,
        ERR_SHORT_HEX,
        ERR_BAD_HEX,
        ERR_UNPAIRED_HIGH,
        ERR_UNPAIRED_LOW,
        ERR_UNTERM
    } t_err;

    // Characters
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_LOWER_B   = 8'h62;
    localparam logic [7:0] CH_LOWER_F   = 8'h66;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_LOWER_U   = 8'h75;
    localparam logic [7:0] CTRL_LIMIT   = 8'h20;

    // Escape replacements
    localparam logic [7:0] BYTE_BS = 8'h08;
    localparam logic [7:0] BYTE_FF = 8'h0C;
    localparam logic [7:0] BYTE_LF = 8'h0A;
    localparam logic [7:0] BYTE_CR = 8'h0D;
    localparam logic [7:0] BYTE_HT = 8'h09;

    // Surrogate ranges and code point limits
    localparam logic [15:0] SUR_HIGH_LO = 16'hD800;
    localparam logic [15:0] SUR_HIGH_HI = 16'hDBFF;
    localparam logic [15:0] SUR_LOW_LO  = 16'hDC00;
    localparam logic [15:0] SUR_LOW_HI  = 16'hDFFF;
    localparam logic [10:0] PLANE_OFF   = 11'h040;   // 0x10000 >> 10
    localparam logic [20:0] UTF8_MAX1   = 21'h00007F;
    localparam logic [20:0] UTF8_MAX2   = 21'h0007FF;
    localparam logic [20:0] UTF8_MAX3   = 21'h00FFFF;
    localparam logic [7:0]  LEAD2       = 8'hC0;
    localparam logic [7:0]  LEAD3       = 8'hE0;
    localparam logic [7:0]  LEAD4       = 8'hF0;
    localparam logic [7:0]  CONT        = 8'h80;

    localparam logic [2:0] HEX_DIGITS = 3'd4;

    // Request queue between parser and serializer
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Results one text byte causes: up to four bytes and a terminal mark
    typedef struct packed {
        logic [2:0]      nbytes;
        logic [3:0][7:0] bytes;
        logic            term;
        t_kind           term_kind;
        t_err            err;
    } t_cmd;

    typedef struct packed {
        logic [2:0]      nbytes;
        logic [3:0][7:0] bytes;
    } t_utf8;

    // Decode one hex digit; bit 4 flags a non-hex character
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
            return {1'b0, d[3:0]};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
            return {1'b0, d[3:0]};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
            return {1'b0, d[3:0]};
        end
        return 5'h10;
    endfunction

    // Encode a code point as UTF-8, first byte in slot zero
    function automatic t_utf8 utf8_encode(input logic [20:0] cp);
        t_utf8 enc;
        enc = '0;
        if (cp <= UTF8_MAX1) begin
            enc.nbytes   = 3'd1;
            enc.bytes[0] = cp[7:0];
        end else if (cp <= UTF8_MAX2) begin
            enc.nbytes   = 3'd2;
            enc.bytes[0] = LEAD2 | {3'b000, cp[10:6]};
            enc.bytes[1] = CONT | {2'b00, cp[5:0]};
        end else if (cp <= UTF8_MAX3) begin
            enc.nbytes   = 3'd3;
            enc.bytes[0] = LEAD3 | {4'b0000, cp[15:12]};
            enc.bytes[1] = CONT | {2'b00, cp[11:6]};
            enc.bytes[2] = CONT | {2'b00, cp[5:0]};
        end else begin
            enc.nbytes   = 3'd4;
            enc.bytes[0] = LEAD4 | {5'b00000, cp[20:18]};
            enc.bytes[1] = CONT | {2'b00, cp[17:12]};
            enc.bytes[2] = CONT | {2'b00, cp[11:6]};
            enc.bytes[3] = CONT | {2'b00, cp[5:0]};
        end
        return enc;
    endfunction

endpackage

FILE: rtl/jsu_front.sv
// Parser front end: accepts text bytes, tracks string state, builds result requests.
module jsu_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [7:0]   i_text_byte,
    input  logic         i_text_ends,
    input  logic         i_space,
    output logic         o_push,
    output jsu_pkg::t_cmd o_cmd,
    output logic         o_idle
);
    import jsu_pkg::*;

    t_mode       r_mode, n_mode;
    logic [2:0]  r_hex_count, n_hex_count;
    logic [15:0] r_hex_value, n_hex_value;
    logic        r_hex_bad, n_hex_bad;
    logic [9:0]  r_high_bits, n_high_bits;

    logic        w_accept;
    logic [4:0]  w_nib;
    logic [15:0] w_val;
    logic        w_bad;
    logic [2:0]  w_cnt;
    logic [10:0] w_plane;
    t_utf8       w_enc_bmp;
    t_utf8       w_enc_pair;
    logic        w_idle_ws;
    t_cmd        w_cmd;

    assign o_ready  = i_space;
    assign w_accept = i_valid && i_space;
    assign o_idle   = (r_mode == MODE_IDLE);

    // Shift the next hex digit into the quad
    assign w_nib      = hex_nibble(i_text_byte);
    assign w_val      = {r_hex_value[11:0], w_nib[4] ? 4'h0 : w_nib[3:0]};
    assign w_bad      = r_hex_bad | w_nib[4];
    assign w_cnt      = r_hex_count + 3'd1;
    assign w_plane    = {1'b0, r_high_bits} + PLANE_OFF;
    assign w_enc_bmp  = utf8_encode({5'd0, w_val});
    assign w_enc_pair = utf8_encode({w_plane, w_val[9:0]});

    // Hold state between requests
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_hex_count <= '0;
            r_hex_value <= '0;
            r_hex_bad   <= 1'b0;
            r_high_bits <= '0;
        end else if (w_accept) begin
            r_mode      <= n_mode;
            r_hex_count <= n_hex_count;
            r_hex_value <= n_hex_value;
            r_hex_bad   <= n_hex_bad;
            r_high_bits <= n_high_bits;
        end
    end

    // Decode the byte in the current mode
    always_comb begin
        n_mode      = r_mode;
        n_hex_count = r_hex_count;
        n_hex_value = r_hex_value;
        n_hex_bad   = r_hex_bad;
        n_high_bits = r_high_bits;
        w_idle_ws   = 1'b0;
        w_cmd       = '0;

        unique case (r_mode)
            MODE_STR: begin
                if (i_text_byte == CH_QUOTE) begin
                    w_cmd.term      = 1'b1;
                    w_cmd.term_kind = KIND_DONE;
                    n_mode          = MODE_IDLE;
                end else if (i_text_byte < CTRL_LIMIT) begin
                    w_cmd.term      = 1'b1;
                    w_cmd.term_kind = KIND_ERROR;
                    w_cmd.err       = ERR_CONTROL;
                    n_mode          = MODE_IDLE;
                end else if (i_text_byte == CH_BACKSLASH) begin
                    n_mode = MODE_ESC;
                end else begin
                    w_cmd.nbytes   = 3'd1;
                    w_cmd.bytes[0] = i_text_byte;
                end
            end
            MODE_ESC: begin
                n_mode       = MODE_STR;
                w_cmd.nbytes = 3'd1;
                unique case (i_text_byte) inside
                    CH_QUOTE, CH_BACKSLASH, CH_SLASH: w_cmd.bytes[0] = i_text_byte;
                    CH_LOWER_B: w_cmd.bytes[0] = BYTE_BS;
                    CH_LOWER_F: w_cmd.bytes[0] = BYTE_FF;
                    CH_LOWER_N: w_cmd.bytes[0] = BYTE_LF;
                    CH_LOWER_R: w_cmd.bytes[0] = BYTE_CR;
                    CH_LOWER_T: w_cmd.bytes[0] = BYTE_HT;
                    CH_LOWER_U: begin
                        w_cmd.nbytes = 3'd0;
                        n_mode       = MODE_HEX1;
                        n_hex_count  = '0;
                        n_hex_value  = '0;
                        n_hex_bad    = 1'b0;
                    end
                    default: begin
                        w_cmd.nbytes    = 3'd0;
                        w_cmd.term      = 1'b1;
                        w_cmd.term_kind = KIND_ERROR;
                        w_cmd.err       = ERR_BAD_ESC;
                        n_mode          = MODE_IDLE;
                    end
                endcase
            end
            MODE_HEX1: begin
                n_hex_count = w_cnt;
                n_hex_value = w_val;
                n_hex_bad   = w_bad;
                if (w_cnt == HEX_DIGITS) begin
                    if (w_bad) begin
                        w_cmd.term      = 1'b1;
                        w_cmd.term_kind = KIND_ERROR;
                        w_cmd.err       = ERR_BAD_HEX;
                        n_mode          = MODE_IDLE;
                    end else if (w_val >= SUR_HIGH_LO && w_val <= SUR_HIGH_HI) begin
                        n_high_bits = w_val[9:0];
                        n_mode      = MODE_SBS;
                    end else if (w_val >= SUR_LOW_LO && w_val <= SUR_LOW_HI) begin
                        w_cmd.term      = 1'b1;
                        w_cmd.term_kind = KIND_ERROR;
                        w_cmd.err       = ERR_UNPAIRED_LOW;
                        n_mode          = MODE_IDLE;
                    end else begin
                        w_cmd.nbytes = w_enc_bmp.nbytes;
                        w_cmd.bytes  = w_enc_bmp.bytes;
                        n_mode       = MODE_STR;
                    end
                end
            end
            MODE_SBS: begin
                if (i_text_byte == CH_BACKSLASH) begin
                    n_mode = MODE_SU;
                end else begin
                    w_cmd.term      = 1'b1;
                    w_cmd.term_kind = KIND_ERROR;
                    w_cmd.err       = ERR_UNPAIRED_HIGH;
                    n_mode          = MODE_IDLE;
                end
            end
            MODE_SU: begin
                if (i_text_byte == CH_LOWER_U) begin
                    n_mode      = MODE_HEX2;
                    n_hex_count = '0;
                    n_hex_value = '0;
                    n_hex_bad   = 1'b0;
                end else begin
                    w_cmd.term      = 1'b1;
                    w_cmd.term_kind = KIND_ERROR;
                    w_cmd.err       = ERR_UNPAIRED_HIGH;
                    n_mode          = MODE_IDLE;
                end
            end
            MODE_HEX2: begin
                n_hex_count = w_cnt;
                n_hex_value = w_val;
                n_hex_bad   = w_bad;
                if (w_cnt == HEX_DIGITS) begin
                    if (w_bad || w_val < SUR_LOW_LO || w_val > SUR_LOW_HI) begin
                        w_cmd.term      = 1'b1;
                        w_cmd.term_kind = KIND_ERROR;
                        w_cmd.err       = ERR_UNPAIRED_HIGH;
                        n_mode          = MODE_IDLE;
                    end else begin
                        w_cmd.nbytes = w_enc_pair.nbytes;
                        w_cmd.bytes  = w_enc_pair.bytes;
                        n_mode       = MODE_STR;
                    end
                end
            end
            default: begin
                if (i_text_byte == CH_SPACE ||
                    (i_text_byte >= CH_TAB && i_text_byte <= CH_CR)) begin
                    w_idle_ws = 1'b1;
                end else if (i_text_byte == CH_QUOTE) begin
                    n_mode = MODE_STR;
                end else begin
                    w_cmd.term      = 1'b1;
                    w_cmd.term_kind = KIND_ERROR;
                    w_cmd.err       = ERR_EXPECTED;
                    n_mode          = MODE_IDLE;
                end
            end
        endcase

        // Close out an open string, or flag a missing string, when the text ends
        if (i_text_ends) begin
            if (w_idle_ws) begin
                w_cmd.term      = 1'b1;
                w_cmd.term_kind = KIND_ERROR;
                w_cmd.err       = ERR_EXPECTED;
            end else begin
                unique case (n_mode)
                    MODE_STR: begin
                        w_cmd.term      = 1'b1;
                        w_cmd.term_kind = KIND_ERROR;
                        w_cmd.err       = ERR_UNTERM;
                    end
                    MODE_ESC: begin
                        w_cmd.term      = 1'b1;
                        w_cmd.term_kind = KIND_ERROR;
                        w_cmd.err       = ERR_UNTERM_ESC;
                    end
                    MODE_HEX1: begin
                        w_cmd.term      = 1'b1;
                        w_cmd.term_kind = KIND_ERROR;
                        w_cmd.err       = ERR_SHORT_HEX;
                    end
                    MODE_SBS, MODE_SU, MODE_HEX2: begin
                        w_cmd.term      = 1'b1;
                        w_cmd.term_kind = KIND_ERROR;
                        w_cmd.err       = ERR_UNPAIRED_HIGH;
                    end
                    default: begin
                        w_cmd.term = w_cmd.term;
                    end
                endcase
            end
            n_mode = MODE_IDLE;
        end
    end

    // Queue only requests that produce results
    assign o_push = w_accept && (w_cmd.nbytes != 3'd0 || w_cmd.term);
    assign o_cmd  = w_cmd;

endmodule

FILE: rtl/jsu_fifo.sv
// Short request queue between parser front end and result serializer.
module jsu_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jsu_pkg::t_cmd i_cmd,
    output logic          o_space,
    output logic          o_valid,
    output jsu_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    import jsu_pkg::*;

    localparam logic [QCW-1:0] FULL_COUNT = QCW'(QDEPTH);

    t_cmd           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QCW-1:0] r_cnt;

    assign o_space = (r_cnt != FULL_COUNT);
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];

    // Store incoming requests
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QAW'(QDEPTH - 1)) ? '0 : r_wp + QAW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == QAW'(QDEPTH - 1)) ? '0 : r_rp + QAW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + QCW'(1);
                2'b01:   r_cnt <= r_cnt - QCW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: rtl/jsu_back.sv
// Result serializer: walks each queued request and drives the output register.
module jsu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  jsu_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_out_byte,
    output logic [1:0]    o_kind,
    output logic [3:0]    o_err_code,
    output logic          o_last
);
    import jsu_pkg::*;

    logic       r_valid;
    logic [2:0] r_idx;
    logic [7:0] r_byte;
    t_kind      r_kind;
    logic [3:0] r_err;
    logic       r_last;

    logic [2:0] w_total;
    logic       w_is_byte;
    logic       w_last;
    logic       w_load;

    // Pick the next result of the head request
    assign w_total   = i_cmd.nbytes + {2'b00, i_cmd.term};
    assign w_is_byte = (r_idx < i_cmd.nbytes);
    assign w_last    = (r_idx == w_total - 3'd1);
    assign w_load    = i_cmd_valid && (!r_valid || i_ready);
    assign o_pop     = w_load && w_last;

    // Advance through the request and hold the output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (w_load) begin
            r_valid <= 1'b1;
            r_idx   <= w_last ? 3'd0 : r_idx + 3'd1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Load the output payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= w_is_byte ? i_cmd.bytes[r_idx[1:0]] : 8'h00;
            r_kind <= w_is_byte ? KIND_BYTE : i_cmd.term_kind;
            r_err  <= (!w_is_byte && i_cmd.term_kind == KIND_ERROR) ? i_cmd.err : 4'h0;
            r_last <= w_last;
        end
    end

    assign o_valid    = r_valid;
    assign o_out_byte = r_byte;
    assign o_kind     = r_kind;
    assign o_err_code = r_err;
    assign o_last     = r_last;

endmodule

FILE: rtl/json_string_unescape.sv
// An accepted byte's results pass first through the request queue, then the output register.
// Throughput: one text byte per cycle while the queue has space; results leave at one per cycle while i_ready is high.
// A \u escape releases up to four UTF-8 bytes plus a mark, drained from a 4-deep queue.
// Reset (synchronous, active low) empties queue and output and returns the parser to idle.
`include "assert_macros.svh"

// Top level of the JSON string unescaper.
module json_string_unescape (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_text_byte,
    input  logic       i_text_ends,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_kind,
    output logic [3:0] o_err_code,
    output logic       o_last
);
    import jsu_pkg::*;

    logic w_space;
    logic w_push;
    t_cmd w_push_cmd;
    logic w_front_idle;
    logic w_head_valid;
    t_cmd w_head_cmd;
    logic w_pop;

    jsu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_text_byte (i_text_byte),
        .i_text_ends (i_text_ends),
        .i_space     (w_space),
        .o_push      (w_push),
        .o_cmd       (w_push_cmd),
        .o_idle      (w_front_idle)
    );

    jsu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_space (w_space),
        .o_valid (w_head_valid),
        .o_cmd   (w_head_cmd),
        .i_pop   (w_pop)
    );

    jsu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_head_valid),
        .i_cmd       (w_head_cmd),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_kind      (o_kind),
        .o_err_code  (o_err_code),
        .o_last      (o_last)
    );

    // Byte results carry no error code
    `JSU_ASSERT(a_byte_no_err, !(o_valid && o_kind == KIND_BYTE) || o_err_code == 4'h0, "byte with code")
    // A completion or error mark is always the final result of its byte
    `JSU_ASSERT(a_mark_last, !(o_valid && o_kind != KIND_BYTE) || (o_last && o_out_byte == 8'h00), "bad mark")
    // The text ending always leaves the parser idle
    `JSU_ASSERT_NEXT(a_ends_idle, i_valid && o_ready && i_text_ends, w_front_idle, "parser not idle")

endmodule
